FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sbd_pkg.sv
// Shared types and constants of the sync word deframer.
package sbd_pkg;

    localparam int SBD_MAX_PACKET_BYTES = 256;

    // Mode codes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SYNC   = 2'd1;
    localparam logic [1:0] MODE_PACKET = 2'd2;

    // Status codes of a result
    localparam logic [1:0] ST_BUSY        = 2'd0;
    localparam logic [1:0] ST_DONE        = 2'd1;
    localparam logic [1:0] ST_BAD_VERSION = 2'd2;
    localparam logic [1:0] ST_BAD_TYPE    = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_OFFSET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_TYPE_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE_CODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_LENGTH      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH      = 3'd7;

    // Framing constants
    localparam logic [7:0] SYNC_BYTE0      = 8'hAA;
    localparam logic [7:0] SYNC_BYTE1      = 8'h55;
    localparam logic [7:0] SYNC_BYTE2      = 8'h42;
    localparam logic [7:0] SYNC_SEED       = 8'h80;
    localparam logic [7:0] ZERO_RUN_THRESH = 8'd32;
    localparam logic [7:0] ZERO_RUN_MAX    = 8'd255;
    localparam logic [7:0] ZERO_RUN_NULL   = 8'd8;
    localparam logic [3:0] BITS_SEED       = 4'd6;
    localparam logic [3:0] BITS_BYTE       = 4'd8;
    localparam logic [3:0] BITS_RESET      = 4'd9;

    typedef struct packed {
        logic [6:0] header_len;
        logic [5:0] version_offset;
        logic [5:0] type_offset;
        logic [7:0] expected_version;
        logic [7:0] ctrl_type_code;
        logic [7:0] data_type_code;
        logic [8:0] ctrl_length;
        logic [8:0] data_length;
    } sbd_cfg_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [1:0] status;
    } sbd_result_t;

endpackage

FILE: design/sbd_cfg_regs.sv
// Configuration register file of the sync word deframer.
module sbd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]  wr_data,
    output sbd_pkg::sbd_cfg_t               cfg
);
    import sbd_pkg::*;

    sbd_cfg_t cfg_reg;
    sbd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_HEADER_LEN:       cfg_next.header_len       = wr_data[6:0];
                REG_VERSION_OFFSET:   cfg_next.version_offset   = wr_data[5:0];
                REG_TYPE_OFFSET:      cfg_next.type_offset      = wr_data[5:0];
                REG_EXPECTED_VERSION: cfg_next.expected_version = wr_data[7:0];
                REG_CTRL_TYPE_CODE:   cfg_next.ctrl_type_code   = wr_data[7:0];
                REG_DATA_TYPE_CODE:   cfg_next.data_type_code   = wr_data[7:0];
                REG_CTRL_LENGTH:      cfg_next.ctrl_length      = wr_data;
                REG_DATA_LENGTH:      cfg_next.data_length      = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_len       <= 7'd4;
            cfg_reg.version_offset   <= 6'd0;
            cfg_reg.type_offset      <= 6'd1;
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.ctrl_type_code   <= 8'd0;
            cfg_reg.data_type_code   <= 8'd1;
            cfg_reg.ctrl_length      <= 9'd16;
            cfg_reg.data_length      <= 9'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/sbd_core.sv
// Deframer state and the one-bit step logic: zero run, sync hunt, packet bytes.
module sbd_core #(
    parameter int MAX_PACKET_BYTES = sbd_pkg::SBD_MAX_PACKET_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic                  bit_in,
    input  sbd_pkg::sbd_cfg_t     cfg,
    output logic                  res_valid,
    output sbd_pkg::sbd_result_t  res
);
    import sbd_pkg::*;

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LW = (PW > 9) ? PW : 9;
    localparam int HW = (PW > 8) ? PW : 8;
    localparam int OW = (PW > 6) ? PW : 6;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_PACKET_BYTES);
    localparam logic [HW-1:0] MAX_H = HW'(MAX_PACKET_BYTES);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_PACKET_BYTES);

    function automatic logic [PW-1:0] clamp_len(input logic [8:0] len);
        logic [PW-1:0] r;
        if (len == 9'd0)
            r = PW'(1);
        else if (LW'(len) > MAX_L)
            r = MAX_P;
        else
            r = PW'(len);
        return r;
    endfunction

    logic [1:0]    mode_reg, mode_next;
    logic [7:0]    zero_run_reg, zero_run_next;
    logic [3:0]    bits_left_reg, bits_left_next;
    logic [7:0]    shift_byte_reg, shift_byte_next;
    logic [1:0]    sync_seen_reg, sync_seen_next;
    logic [7:0]    sync0_reg, sync0_next;
    logic [7:0]    sync1_reg, sync1_next;
    logic [PW-1:0] total_reg, total_next;
    logic [PW-1:0] done_reg, done_next;
    logic [7:0]    version_reg, version_next;
    logic [7:0]    type_reg, type_next;

    logic [7:0]    shifted;
    logic [3:0]    bits_dec;
    logic [HW-1:0] hdr_plus;
    logic [PW-1:0] check_at;
    logic [PW-1:0] ctrl_total;
    logic [PW-1:0] data_total;
    logic [1:0]    seen_inc;
    logic          check_now;
    logic          got;
    logic [1:0]    status;

    assign shifted    = {bit_in, shift_byte_reg[7:1]};
    assign bits_dec   = bits_left_reg - 4'd1;
    assign hdr_plus   = HW'(cfg.header_len) + HW'(1);
    assign check_at   = (hdr_plus > MAX_H) ? MAX_P : PW'(hdr_plus);
    assign ctrl_total = clamp_len(cfg.ctrl_length);
    assign data_total = clamp_len(cfg.data_length);
    assign seen_inc   = sync_seen_reg + 2'd1;
    assign check_now  = (total_reg == '0) && (done_reg >= check_at);

    always_comb begin
        mode_next       = mode_reg;
        zero_run_next   = zero_run_reg;
        bits_left_next  = bits_left_reg;
        shift_byte_next = shift_byte_reg;
        sync_seen_next  = sync_seen_reg;
        sync0_next      = sync0_reg;
        sync1_next      = sync1_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        got             = 1'b0;
        status          = ST_BUSY;
        res             = '0;
        res_valid       = 1'b0;

        case (mode_reg)
            MODE_IDLE: begin
                if (zero_run_reg > ZERO_RUN_THRESH) begin
                    if (bit_in) begin
                        mode_next       = MODE_SYNC;
                        bits_left_next  = BITS_SEED;
                        shift_byte_next = SYNC_SEED;
                        sync_seen_next  = 2'd0;
                    end else if (zero_run_reg < ZERO_RUN_MAX) begin
                        zero_run_next = zero_run_reg + 8'd1;
                    end
                end else begin
                    zero_run_next = bit_in ? 8'd0 : zero_run_reg + 8'd1;
                end
            end

            MODE_SYNC: begin
                shift_byte_next = shifted;
                bits_left_next  = bits_dec;
                if (bits_dec == 4'd0) begin
                    if (shifted == 8'd0) begin
                        mode_next     = MODE_IDLE;
                        zero_run_next = ZERO_RUN_NULL;
                    end else begin
                        if (sync_seen_reg == 2'd0)
                            sync0_next = shifted;
                        else if (sync_seen_reg == 2'd1)
                            sync1_next = shifted;
                        sync_seen_next = seen_inc;
                        // third byte is compared as it arrives
                        if (seen_inc == 2'd3) begin
                            if (sync0_reg == SYNC_BYTE0 && sync1_reg == SYNC_BYTE1 &&
                                shifted == SYNC_BYTE2) begin
                                mode_next  = MODE_PACKET;
                                total_next = '0;
                                done_next  = '0;
                            end else begin
                                mode_next     = MODE_IDLE;
                                zero_run_next = 8'd0;
                            end
                        end
                        bits_left_next  = BITS_BYTE;
                        shift_byte_next = 8'd0;
                    end
                end
            end

            MODE_PACKET: begin
                if (check_now) begin
                    if (version_reg != cfg.expected_version)
                        status = ST_BAD_VERSION;
                    else if (type_reg == cfg.ctrl_type_code)
                        total_next = ctrl_total;
                    else if (type_reg == cfg.data_type_code)
                        total_next = data_total;
                    else
                        status = ST_BAD_TYPE;
                end

                if (status != ST_BUSY) begin
                    // abandon: drop this bit
                    total_next    = total_reg;
                    mode_next     = MODE_IDLE;
                    zero_run_next = 8'd0;
                    res.status    = status;
                    res_valid     = 1'b1;
                end else begin
                    shift_byte_next = shifted;
                    bits_left_next  = bits_dec;
                    if (bits_dec == 4'd0) begin
                        got            = 1'b1;
                        res.has_byte   = 1'b1;
                        res.byte_value = shifted;
                        res.byte_index = 8'(done_reg);
                        if (OW'(done_reg) == OW'(cfg.version_offset))
                            version_next = shifted;
                        if (OW'(done_reg) == OW'(cfg.type_offset))
                            type_next = shifted;
                        done_next       = done_reg + PW'(1);
                        bits_left_next  = BITS_BYTE;
                        shift_byte_next = 8'd0;
                    end
                    if (total_next != '0 && done_next >= total_next) begin
                        res.status    = ST_DONE;
                        mode_next     = MODE_IDLE;
                        zero_run_next = 8'd0;
                    end
                    res_valid = got || (res.status != ST_BUSY);
                end
            end

            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            zero_run_reg   <= 8'd0;
            bits_left_reg  <= BITS_RESET;
            shift_byte_reg <= 8'd0;
            sync_seen_reg  <= 2'd0;
            total_reg      <= '0;
            done_reg       <= '0;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            zero_run_reg   <= zero_run_next;
            bits_left_reg  <= bits_left_next;
            shift_byte_reg <= shift_byte_next;
            sync_seen_reg  <= sync_seen_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
        end
    end

    // header and sync bytes hold garbage until written
    always_ff @(posedge aclk) begin
        if (step_en) begin
            sync0_reg   <= sync0_next;
            sync1_reg   <= sync1_next;
            version_reg <= version_next;
            type_reg    <= type_next;
        end
    end

endmodule

FILE: design/bit_stream_sync_deframer.sv
// Top level of the bit stream sync word deframer.
//
// Input channel s_valid/s_ready carries one demodulated bit (s_bit_in) per
// transfer. The block counts a run of zeros, hunts for the sync bytes
// AA 55 42 packed LSB first, then assembles packet bytes and checks the
// header version and type bytes against the configuration registers.
// Result channel m_valid/m_ready carries one result per completed packet
// byte or per status event (packet complete, bad version, unknown type);
// bits that complete nothing produce no transfer.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; writes
// are taken every cycle and must only happen while the block is idle.
// A bit held in the input register is stepped when the result slot is free
// or being drained, and its result is loaded into the result register on m_*.
// Throughput: one bit per cycle while the result is not stalled, set by the
// single step stage between the input register and the result register.
// Reset (aresetn low, synchronous) returns to zero-run counting, clears the
// valid flags of both channel registers and reloads the configuration defaults.
// When the receiver stalls, the result holds and the input register takes
// one more bit, then s_ready drops until the result is taken.
module bit_stream_sync_deframer #(
    parameter int MAX_PACKET_BYTES = sbd_pkg::SBD_MAX_PACKET_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_bit_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_has_byte,
    output logic [7:0]                      m_byte_value,
    output logic [7:0]                      m_byte_index,
    output logic [1:0]                      m_status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sbd_pkg::*;

    sbd_cfg_t    cfg;
    sbd_result_t res;
    sbd_result_t out_reg;
    logic        res_valid;
    logic        in_valid_reg;
    logic        in_bit_reg;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;

    // step the held bit whenever the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sbd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sbd_core #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .bit_in    (in_bit_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= res_valid;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_bit_reg <= s_bit_in;
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_valid      = out_valid_reg;
    assign m_has_byte   = out_reg.has_byte;
    assign m_byte_value = out_reg.byte_value;
    assign m_byte_index = out_reg.byte_index;
    assign m_status     = out_reg.status;

endmodule

FILE: design/sbd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "assert_macros.svh"

module sbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_has_byte,
    input logic [7:0]  m_byte_value,
    input logic [7:0]  m_byte_index,
    input logic [1:0]  m_status
);
    import sbd_pkg::*;

    // stalled result holds
    `SBD_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `SBD_ASSERT_NXT(a_m_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_status) && $stable(m_has_byte) && $stable(m_byte_value) && $stable(m_byte_index), "result changed while stalled")
    // a transfer without a byte only reports a status event
    `SBD_ASSERT_IMP(a_nobyte_status, aclk, aresetn, m_valid && !m_has_byte, m_status != ST_BUSY, "empty result with busy status")
    `SBD_ASSERT_IMP(a_nobyte_zero, aclk, aresetn, m_valid && !m_has_byte, m_byte_value == 8'd0 && m_byte_index == 8'd0, "empty result carries byte fields")

endmodule

bind bit_stream_sync_deframer sbd_checker u_sbd_checker (.*);
